@@ rtl/core/adpu_pkg.sv @@
// ----------------------------------------------------------------------------
// adpu_pkg: shared types and codes for the ARM data-processing unit
// Opcode, condition and shift-type codes, field positions and the structs
// that pass between the shifter, the ALU and the top level.
// ----------------------------------------------------------------------------
package adpu_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned FLAGS_W    = 4;
	localparam int unsigned REG_IDX_W  = 4;
	localparam int unsigned IN_DATA_W  = 96;
	localparam int unsigned OUT_BITS_W = 42;
	localparam int unsigned OUT_DATA_W = 48;

	localparam logic [WORD_W-1:0] SIGN_BIT   = 32'h8000_0000;
	localparam logic [WORD_W-1:0] CLASS_MASK = 32'h0C00_0000;

	// Flag positions inside the NZCV nibble
	localparam int unsigned FLAG_N = 3;
	localparam int unsigned FLAG_Z = 2;
	localparam int unsigned FLAG_C = 1;
	localparam int unsigned FLAG_V = 0;

	typedef enum logic [3:0] {
		OP_AND = 4'h0,
		OP_EOR = 4'h1,
		OP_SUB = 4'h2,
		OP_RSB = 4'h3,
		OP_ADD = 4'h4,
		OP_ADC = 4'h5,
		OP_SBC = 4'h6,
		OP_RSC = 4'h7,
		OP_TST = 4'h8,
		OP_TEQ = 4'h9,
		OP_CMP = 4'hA,
		OP_CMN = 4'hB,
		OP_ORR = 4'hC,
		OP_MOV = 4'hD,
		OP_BIC = 4'hE,
		OP_MVN = 4'hF
	} opcode_t;

	typedef enum logic [3:0] {
		COND_EQ = 4'h0,
		COND_NE = 4'h1,
		COND_CS = 4'h2,
		COND_CC = 4'h3,
		COND_MI = 4'h4,
		COND_PL = 4'h5,
		COND_VS = 4'h6,
		COND_VC = 4'h7,
		COND_HI = 4'h8,
		COND_LS = 4'h9,
		COND_GE = 4'hA,
		COND_LT = 4'hB,
		COND_GT = 4'hC,
		COND_LE = 4'hD,
		COND_AL = 4'hE,
		COND_NV = 4'hF
	} cond_t;

	typedef enum logic [1:0] {
		SHIFT_LSL = 2'd0,
		SHIFT_LSR = 2'd1,
		SHIFT_ASR = 2'd2,
		SHIFT_ROR = 2'd3
	} shift_t;

	// Operand 2 from the barrel shifter
	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              carry;
	} operand2_t;

	// Outcome of one instruction from the ALU
	typedef struct packed {
		logic                 executed;
		logic                 write_enable;
		logic [REG_IDX_W-1:0] dest_index;
		logic [WORD_W-1:0]    result_value;
		logic [FLAGS_W-1:0]   flags_out;
		logic                 flags_upd;
	} alu_res_t;

endpackage

@@ rtl/core/adpu_shifter.sv @@
// ----------------------------------------------------------------------------
// adpu_shifter: operand 2 barrel shifter
// Forms operand 2 from a rotated 8-bit immediate or from an immediate-amount
// LSL, LSR, ASR, ROR or RRX of the register operand, with shifter carry.
// ----------------------------------------------------------------------------
module adpu_shifter (
	input  logic [adpu_pkg::WORD_W-1:0] instruction,
	input  logic [adpu_pkg::WORD_W-1:0] shift_operand,
	input  logic                        carry_in,
	output adpu_pkg::operand2_t         op2
);

	logic [4:0]                      rot;
	logic [4:0]                      amt;
	logic [adpu_pkg::WORD_W-1:0]     imm32;
	logic [2*adpu_pkg::WORD_W-1:0]   imm_wide;
	logic [2*adpu_pkg::WORD_W-1:0]   ror_wide;
	logic [adpu_pkg::WORD_W:0]       lsl_ext;
	logic [adpu_pkg::WORD_W:0]       lsr_ext;
	logic signed [adpu_pkg::WORD_W:0] asr_ext;
	adpu_pkg::shift_t                kind;

	assign rot   = {instruction[11:8], 1'b0};
	assign amt   = instruction[11:7];
	assign imm32 = {24'd0, instruction[7:0]};
	assign kind  = adpu_pkg::shift_t'(instruction[6:5]);

	// Rotate the immediate and shift the register in every form at once
	always_comb begin
		imm_wide = {imm32, imm32} >> rot;
		ror_wide = {shift_operand, shift_operand} >> amt;
		lsl_ext  = {1'b0, shift_operand} << amt;
		lsr_ext  = {shift_operand, 1'b0} >> amt;
		asr_ext  = $signed({shift_operand, 1'b0}) >>> amt;
	end

	// Select the form and its carry
	always_comb begin
		op2 = '0;
		if (instruction[25]) begin
			op2.value = imm_wide[adpu_pkg::WORD_W-1:0];
			op2.carry = (rot == 5'd0) ? carry_in : imm_wide[adpu_pkg::WORD_W-1];
		end else begin
			case (kind)
				adpu_pkg::SHIFT_LSL: begin
					if (amt == 5'd0) begin
						op2.value = shift_operand;
						op2.carry = carry_in;
					end else begin
						op2.value = lsl_ext[adpu_pkg::WORD_W-1:0];
						op2.carry = lsl_ext[adpu_pkg::WORD_W];
					end
				end
				adpu_pkg::SHIFT_LSR: begin
					// zero amount means a shift by 32
					if (amt == 5'd0) begin
						op2.value = '0;
						op2.carry = shift_operand[adpu_pkg::WORD_W-1];
					end else begin
						op2.value = lsr_ext[adpu_pkg::WORD_W:1];
						op2.carry = lsr_ext[0];
					end
				end
				adpu_pkg::SHIFT_ASR: begin
					if (amt == 5'd0) begin
						op2.value = {adpu_pkg::WORD_W{shift_operand[adpu_pkg::WORD_W-1]}};
						op2.carry = shift_operand[adpu_pkg::WORD_W-1];
					end else begin
						op2.value = asr_ext[adpu_pkg::WORD_W:1];
						op2.carry = asr_ext[0];
					end
				end
				adpu_pkg::SHIFT_ROR: begin
					// zero amount is RRX through the stored carry
					if (amt == 5'd0) begin
						op2.value = {carry_in, shift_operand[adpu_pkg::WORD_W-1:1]};
						op2.carry = shift_operand[0];
					end else begin
						op2.value = ror_wide[adpu_pkg::WORD_W-1:0];
						op2.carry = ror_wide[adpu_pkg::WORD_W-1];
					end
				end
				default: begin
					op2.value = shift_operand;
					op2.carry = carry_in;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/adpu_alu.sv @@
// ----------------------------------------------------------------------------
// adpu_alu: condition check and 16-opcode ALU
// Checks the condition field against the stored flags, runs the opcode on
// the first operand and operand 2 and forms the new NZCV flags.
// ----------------------------------------------------------------------------
module adpu_alu (
	input  logic [adpu_pkg::WORD_W-1:0]  instruction,
	input  logic [adpu_pkg::WORD_W-1:0]  first_operand,
	input  adpu_pkg::operand2_t          op2,
	input  logic [adpu_pkg::FLAGS_W-1:0] flags,
	output adpu_pkg::alu_res_t           res
);

	logic                        fn, fz, fc, fv;
	logic                        accepted;
	logic                        cond_ok;
	logic                        exec;
	adpu_pkg::cond_t             cond;
	adpu_pkg::opcode_t           opc;
	logic [adpu_pkg::WORD_W-1:0] a, b;
	logic [adpu_pkg::WORD_W-1:0] add_x, add_y;
	logic                        add_ci;
	logic                        is_arith;
	logic [adpu_pkg::WORD_W:0]   sum;
	logic [adpu_pkg::WORD_W-1:0] logic_res;
	logic [adpu_pkg::WORD_W-1:0] result;
	logic                        c_new, v_new;

	assign fn   = flags[adpu_pkg::FLAG_N];
	assign fz   = flags[adpu_pkg::FLAG_Z];
	assign fc   = flags[adpu_pkg::FLAG_C];
	assign fv   = flags[adpu_pkg::FLAG_V];
	assign cond = adpu_pkg::cond_t'(instruction[31:28]);
	assign opc  = adpu_pkg::opcode_t'(instruction[24:21]);
	assign a    = first_operand;
	assign b    = op2.value;

	// Drop other instruction classes and register-specified shifts
	assign accepted = ((instruction & adpu_pkg::CLASS_MASK) == '0) &&
	                  !(!instruction[25] && instruction[4]);

	// Evaluate the condition field
	always_comb begin
		case (cond)
			adpu_pkg::COND_EQ: cond_ok = fz;
			adpu_pkg::COND_NE: cond_ok = !fz;
			adpu_pkg::COND_CS: cond_ok = fc;
			adpu_pkg::COND_CC: cond_ok = !fc;
			adpu_pkg::COND_MI: cond_ok = fn;
			adpu_pkg::COND_PL: cond_ok = !fn;
			adpu_pkg::COND_VS: cond_ok = fv;
			adpu_pkg::COND_VC: cond_ok = !fv;
			adpu_pkg::COND_HI: cond_ok = fc && !fz;
			adpu_pkg::COND_LS: cond_ok = !fc || fz;
			adpu_pkg::COND_GE: cond_ok = (fn == fv);
			adpu_pkg::COND_LT: cond_ok = (fn != fv);
			adpu_pkg::COND_GT: cond_ok = !fz && (fn == fv);
			adpu_pkg::COND_LE: cond_ok = fz || (fn != fv);
			adpu_pkg::COND_AL: cond_ok = 1'b1;
			default:           cond_ok = 1'b0;
		endcase
	end

	assign exec = accepted && cond_ok;

	// Select adder operands; subtraction adds the inverted operand
	always_comb begin
		is_arith = 1'b1;
		add_x    = a;
		add_y    = b;
		add_ci   = 1'b0;
		case (opc)
			adpu_pkg::OP_SUB, adpu_pkg::OP_CMP: begin
				add_y  = ~b;
				add_ci = 1'b1;
			end
			adpu_pkg::OP_RSB: begin
				add_x  = b;
				add_y  = ~a;
				add_ci = 1'b1;
			end
			adpu_pkg::OP_ADD, adpu_pkg::OP_CMN: add_ci = 1'b0;
			adpu_pkg::OP_ADC: add_ci = fc;
			adpu_pkg::OP_SBC: begin
				add_y  = ~b;
				add_ci = fc;
			end
			adpu_pkg::OP_RSC: begin
				add_x  = b;
				add_y  = ~a;
				add_ci = fc;
			end
			default: is_arith = 1'b0;
		endcase
	end

	assign sum = {1'b0, add_x} + {1'b0, add_y} + {{adpu_pkg::WORD_W{1'b0}}, add_ci};

	// Logical opcodes
	always_comb begin
		case (opc)
			adpu_pkg::OP_AND, adpu_pkg::OP_TST: logic_res = a & b;
			adpu_pkg::OP_EOR, adpu_pkg::OP_TEQ: logic_res = a ^ b;
			adpu_pkg::OP_ORR:                   logic_res = a | b;
			adpu_pkg::OP_MOV:                   logic_res = b;
			adpu_pkg::OP_BIC:                   logic_res = a & ~b;
			default:                            logic_res = ~b;
		endcase
	end

	// Pick result and carry/overflow by opcode class
	always_comb begin
		if (is_arith) begin
			result = sum[adpu_pkg::WORD_W-1:0];
			c_new  = sum[adpu_pkg::WORD_W];
			v_new  = |(~(add_x ^ add_y) & (add_x ^ result) & adpu_pkg::SIGN_BIT);
		end else begin
			result = logic_res;
			c_new  = op2.carry;
			v_new  = fv;
		end
	end

	// Assemble the outcome
	always_comb begin
		res              = '0;
		res.executed     = exec;
		res.write_enable = exec && !(opc inside {[adpu_pkg::OP_TST : adpu_pkg::OP_CMN]});
		res.dest_index   = instruction[15:12];
		res.result_value = exec ? result : '0;
		res.flags_upd    = exec && instruction[20];
		if (res.flags_upd) begin
			res.flags_out = {result[adpu_pkg::WORD_W-1], (result == '0), c_new, v_new};
		end else begin
			res.flags_out = flags;
		end
	end

endmodule

@@ rtl/core/arm_data_processing_unit_top.sv @@
// A request is taken into the input register; its shifter and ALU outcome then goes
// into the result register. Throughput: one request per cycle while the result side
// does not stall; the NZCV loop through the shifter and ALU is combinational between
// the two registers. Backpressure on the result side stalls the input register; a new
// request is still taken while one result waits. Reset (arst_n low, asynchronous)
// clears both valid bits and NZCV.
// ----------------------------------------------------------------------------
// arm_data_processing_unit_top: ARM data-processing execute unit
// Input register, barrel shifter and ALU, output register and NZCV flags.
// ----------------------------------------------------------------------------
module arm_data_processing_unit_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [31:0] instruction, [63:32] first_operand, [95:64] shift_operand
	input  logic [adpu_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] executed, [1] write_enable, [5:2] dest_index,
	// [37:6] result_value, [41:38] flags_out, [47:42] zero
	output logic [adpu_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic                                valid_s1;
	logic [adpu_pkg::WORD_W-1:0]         inst_s1;
	logic [adpu_pkg::WORD_W-1:0]         opa_s1;
	logic [adpu_pkg::WORD_W-1:0]         rm_s1;
	logic                                out_valid_q;
	logic [adpu_pkg::OUT_BITS_W-1:0]     out_data_q;
	logic [adpu_pkg::FLAGS_W-1:0]        flags_q;
	logic                                out_free;
	logic                                move_s1;
	logic                                take_in;
	adpu_pkg::operand2_t                 op2;
	adpu_pkg::alu_res_t                  res;

	// Output slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || m_tready;
	assign move_s1  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign take_in  = s_tvalid && s_tready;

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			inst_s1 <= s_tdata[31:0];
			opa_s1  <= s_tdata[63:32];
			rm_s1   <= s_tdata[95:64];
		end
	end

	adpu_shifter u_shifter (
		.instruction   (inst_s1),
		.shift_operand (rm_s1),
		.carry_in      (flags_q[adpu_pkg::FLAG_C]),
		.op2           (op2)
	);

	adpu_alu u_alu (
		.instruction   (inst_s1),
		.first_operand (opa_s1),
		.op2           (op2),
		.flags         (flags_q),
		.res           (res)
	);

	// Flags advance as the instruction leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (move_s1 && res.flags_upd) begin
			flags_q <= res.flags_out;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_data_q <= {res.flags_out, res.result_value, res.dest_index,
			               res.write_enable, res.executed};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(adpu_pkg::OUT_DATA_W - adpu_pkg::OUT_BITS_W){1'b0}}, out_data_q};

`ifndef SYNTHESIS
	// A write is only ever requested by an executed instruction
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] || !m_tdata[1]))
		else $error("write_enable without executed");

	// A skipped instruction returns a zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[37:6] == '0))
		else $error("nonzero result for skipped instruction");

	// Flags change only when an instruction moves to the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		(flags_q != $past(flags_q)) |-> $past(move_s1))
		else $error("flags changed without an instruction");

	// The flags reported with a fresh result match the stored flags
	assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> (m_tdata[41:38] == flags_q))
		else $error("reported flags differ from stored flags");
`endif

endmodule

@@ tb/sv/arm_data_processing_unit_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arm_data_processing_unit_top_tb: self-checking bench for the ARM DP unit
// Streams data-processing requests through the unit under changing
// handshake pressure. Every accepted request runs through a local copy of
// the shifter, ALU and NZCV flags. Each result is checked field by field.
// ----------------------------------------------------------------------------
module arm_data_processing_unit_top_tb;

	import adpu_pkg::*;

	// One request as it sits on s_tdata, last field (instr) in the lowest bits
	typedef struct packed {
		logic [WORD_W-1:0] rm_value;
		logic [WORD_W-1:0] rn_value;
		logic [WORD_W-1:0] instr;
	} dp_request_t;

	typedef struct packed {
		logic                 executed;
		logic                 write_enable;
		logic [REG_IDX_W-1:0] dest_index;
		logic [WORD_W-1:0]    result_value;
		logic [FLAGS_W-1:0]   flags_out;
	} dp_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	dp_request_t pending_requests[$];
	dp_result_t  expected_results[$];
	int          total_requests = 1;
	int          sent_count = 0;
	int          fail_count = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	logic [3:0]  model_nzcv = 4'h0;
	dp_result_t  want_res;
	dp_result_t  got_res;

	arm_data_processing_unit_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Idle percentages: sender light / receiver heavy, then swapped, then none
	function automatic int phase_now();
		return (sent_count * 3) / total_requests;
	endfunction

	function automatic int sender_idle_pct();
		case (phase_now())
			0:       return 17;
			1:       return 82;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (phase_now())
			0:       return 82;
			1:       return 17;
			default: return 0;
		endcase
	endfunction

	// x + y + ci at 32 bits: {carry, overflow, sum}
	function automatic logic [33:0] sum_with_carry(logic [31:0] x, logic [31:0] y, logic ci);
		logic [32:0] s;
		logic        ovf;
		s   = {1'b0, x} + {1'b0, y} + {32'b0, ci};
		ovf = ~(x[31] ^ y[31]) & (x[31] ^ s[31]);
		return {s[32], ovf, s[31:0]};
	endfunction

	// Predict one instruction against the current flags; flags_out is the new state
	function automatic dp_result_t execute_dp(dp_request_t req, logic [3:0] nzcv);
		logic        n, z, c, v;
		logic        cond_ok, accepted, sh_c, alu_c, alu_v, arith;
		logic [31:0] inst, a, rm, b, res, imm8;
		logic [33:0] sum;
		logic [4:0]  amt, rot;
		opcode_t     opc;
		dp_result_t  r;
		inst  = req.instr;
		a     = req.rn_value;
		rm    = req.rm_value;
		n     = nzcv[FLAG_N];
		z     = nzcv[FLAG_Z];
		c     = nzcv[FLAG_C];
		v     = nzcv[FLAG_V];
		res   = '0;
		arith = 1'b0;
		sum   = '0;
		case (cond_t'(inst[31:28]))
			COND_EQ: cond_ok = z;
			COND_NE: cond_ok = !z;
			COND_CS: cond_ok = c;
			COND_CC: cond_ok = !c;
			COND_MI: cond_ok = n;
			COND_PL: cond_ok = !n;
			COND_VS: cond_ok = v;
			COND_VC: cond_ok = !v;
			COND_HI: cond_ok = c && !z;
			COND_LS: cond_ok = !c || z;
			COND_GE: cond_ok = (n == v);
			COND_LT: cond_ok = (n != v);
			COND_GT: cond_ok = !z && (n == v);
			COND_LE: cond_ok = z || (n != v);
			COND_AL: cond_ok = 1'b1;
			default: cond_ok = 1'b0;
		endcase
		// register-specified shifts and other classes are dropped
		accepted = ((inst & CLASS_MASK) == '0) && !(!inst[25] && inst[4]);
		r.executed     = accepted && cond_ok;
		r.write_enable = 1'b0;
		r.dest_index   = inst[15:12];
		r.flags_out    = nzcv;
		opc            = opcode_t'(inst[24:21]);
		if (r.executed) begin
			// form operand 2
			if (inst[25]) begin
				rot  = {inst[11:8], 1'b0};
				imm8 = {24'b0, inst[7:0]};
				b    = (imm8 >> rot) | (imm8 << (32 - rot));
				sh_c = (rot == 0) ? c : b[31];
			end else begin
				amt = inst[11:7];
				case (shift_t'(inst[6:5]))
					SHIFT_LSL: begin
						if (amt == 0) begin
							b = rm; sh_c = c;
						end else begin
							b = rm << amt; sh_c = rm[32 - amt];
						end
					end
					SHIFT_LSR: begin
						if (amt == 0) begin
							b = '0; sh_c = rm[31];
						end else begin
							b = rm >> amt; sh_c = rm[amt - 1];
						end
					end
					SHIFT_ASR: begin
						if (amt == 0) begin
							b = {32{rm[31]}}; sh_c = rm[31];
						end else begin
							b = $signed(rm) >>> amt; sh_c = rm[amt - 1];
						end
					end
					default: begin
						if (amt == 0) begin
							b = {c, rm[31:1]}; sh_c = rm[0];
						end else begin
							b = (rm >> amt) | (rm << (32 - amt)); sh_c = rm[amt - 1];
						end
					end
				endcase
			end
			// run the ALU
			case (opc)
				OP_AND, OP_TST: res = a & b;
				OP_EOR, OP_TEQ: res = a ^ b;
				OP_SUB, OP_CMP: begin sum = sum_with_carry(a, ~b, 1'b1); arith = 1'b1; end
				OP_RSB:         begin sum = sum_with_carry(b, ~a, 1'b1); arith = 1'b1; end
				OP_ADD, OP_CMN: begin sum = sum_with_carry(a, b, 1'b0); arith = 1'b1; end
				OP_ADC:         begin sum = sum_with_carry(a, b, c); arith = 1'b1; end
				OP_SBC:         begin sum = sum_with_carry(a, ~b, c); arith = 1'b1; end
				OP_RSC:         begin sum = sum_with_carry(b, ~a, c); arith = 1'b1; end
				OP_ORR:         res = a | b;
				OP_MOV:         res = b;
				OP_BIC:         res = a & ~b;
				default:        res = ~b;
			endcase
			if (arith) begin
				res   = sum[31:0];
				alu_c = sum[33];
				alu_v = sum[32];
			end else begin
				alu_c = sh_c;
				alu_v = v;
			end
			r.write_enable = !(opc inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
			if (inst[20])
				r.flags_out = {res[31], (res == '0), alu_c, alu_v};
		end
		r.result_value = res;
		return r;
	endfunction

	function automatic logic [31:0] dp_word(cond_t cond, logic imm, opcode_t opc, logic s,
		logic [3:0] rn, logic [3:0] rd, logic [11:0] op2);
		return {cond, 2'b00, imm, opc, s, rn, rd, op2};
	endfunction

	function automatic logic [11:0] shift_field(logic [4:0] amt, shift_t sh, logic [3:0] rm);
		return {amt, sh, 1'b0, rm};
	endfunction

	// Operand values biased toward the edges of the word
	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'h7FFF_FFFF;
			4:       return $urandom_range(3);
			default: return $urandom();
		endcase
	endfunction

	task automatic add_request(logic [31:0] inst, logic [31:0] a, logic [31:0] rm);
		dp_request_t req;
		req.instr    = inst;
		req.rn_value = a;
		req.rm_value = rm;
		pending_requests.push_back(req);
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	// Directed and random requests, reset, then drain and report
	initial begin
		logic [31:0] inst;
		logic [11:0] op2;
		int          pick;
		add_request(dp_word(COND_AL, 1'b1, OP_MOV, 1'b1, 4'h0, 4'h1, 12'h000), 32'h0, 32'h0);
		add_request(dp_word(COND_EQ, 1'b0, OP_ADD, 1'b1, 4'h2, 4'h3,
			shift_field(5'd0, SHIFT_LSL, 4'h4)), 32'hFFFF_FFFF, 32'h1);
		add_request(dp_word(COND_AL, 1'b1, OP_ADC, 1'b1, 4'h5, 4'h6, 12'h4FF),
			32'h7FFF_FFFF, 32'h0);
		add_request(dp_word(COND_AL, 1'b0, OP_SUB, 1'b1, 4'h7, 4'h8,
			shift_field(5'd0, SHIFT_LSR, 4'h9)), 32'h8000_0000, 32'h8000_0000);
		add_request(dp_word(COND_AL, 1'b0, OP_RSB, 1'b1, 4'hA, 4'hB,
			shift_field(5'd0, SHIFT_ASR, 4'hC)), 32'h0, 32'h8000_0000);
		add_request(dp_word(COND_AL, 1'b0, OP_SBC, 1'b1, 4'hD, 4'hE,
			shift_field(5'd0, SHIFT_ASR, 4'hF)), 32'h1234_5678, 32'h7FFF_FFFF);
		add_request(dp_word(COND_AL, 1'b0, OP_RSC, 1'b1, 4'h1, 4'h2,
			shift_field(5'd0, SHIFT_ROR, 4'h3)), 32'h5, 32'h3);
		add_request(dp_word(COND_AL, 1'b0, OP_EOR, 1'b1, 4'h4, 4'h5,
			shift_field(5'd8, SHIFT_ROR, 4'h6)), 32'hA5A5_A5A5, 32'h1234_5678);
		add_request(dp_word(COND_AL, 1'b1, OP_TST, 1'b1, 4'h0, 4'h0, 12'h1FF),
			32'hFFFF_FFFF, 32'h0);
		add_request(dp_word(COND_AL, 1'b0, OP_TEQ, 1'b1, 4'h1, 4'h0,
			shift_field(5'd31, SHIFT_LSL, 4'h2)), 32'h8000_0000, 32'h1);
		add_request(dp_word(COND_AL, 1'b1, OP_CMP, 1'b1, 4'h3, 4'h0, 12'h001),
			32'h8000_0000, 32'h0);
		add_request(dp_word(COND_AL, 1'b1, OP_CMN, 1'b1, 4'h4, 4'h0, 12'h001),
			32'hFFFF_FFFF, 32'h0);
		add_request(dp_word(COND_AL, 1'b0, OP_ORR, 1'b1, 4'h5, 4'h6,
			shift_field(5'd31, SHIFT_ASR, 4'h7)), 32'h0, 32'h8000_0000);
		add_request(dp_word(COND_AL, 1'b0, OP_BIC, 1'b1, 4'h8, 4'h9,
			shift_field(5'd31, SHIFT_LSL, 4'hA)), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_request(dp_word(COND_AL, 1'b1, OP_MVN, 1'b1, 4'hB, 4'hC, 12'hFFF),
			32'h0, 32'h0);
		add_request(dp_word(COND_AL, 1'b0, OP_AND, 1'b1, 4'hD, 4'hE,
			shift_field(5'd1, SHIFT_LSR, 4'hF)), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// compare without S leaves the flags alone
		add_request(dp_word(COND_AL, 1'b1, OP_CMP, 1'b0, 4'h1, 4'h2, 12'h000),
			32'h0, 32'h0);
		// not a data-processing class
		add_request(32'hE590_1004, 32'h1111_1111, 32'h2222_2222);
		// register-specified shift
		add_request(dp_word(COND_AL, 1'b0, OP_ADD, 1'b1, 4'h1, 4'h2, 12'h312),
			32'h3, 32'h4);
		add_request(dp_word(COND_NV, 1'b1, OP_MOV, 1'b1, 4'h0, 4'h3, 12'h0FF),
			32'h0, 32'h0);
		// set Z, then a NE that must fail
		add_request(dp_word(COND_AL, 1'b1, OP_MOV, 1'b1, 4'h0, 4'h4, 12'h000), 32'h0, 32'h0);
		add_request(dp_word(COND_NE, 1'b1, OP_ADD, 1'b1, 4'h1, 4'h5, 12'h0FF),
			32'h1, 32'h0);
		add_request(dp_word(COND_AL, 1'b1, OP_MOV, 1'b0, 4'h0, 4'hF, 12'h0AB), 32'h0, 32'h0);
		add_request(dp_word(COND_AL, 1'b0, OP_ADD, 1'b1, 4'hF, 4'h7,
			shift_field(5'd0, SHIFT_LSL, 4'hF)), 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// random part: mostly well-formed, some broken or unrelated words
		repeat (776) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				inst = $urandom();
			end else begin
				op2 = 12'($urandom_range(4095));
				if ($urandom_range(7) == 0)
					op2[11:7] = 5'd0;
				if (pick >= 15)
					op2[4] = 1'b0;
				inst = dp_word(($urandom_range(1) != 0) ? COND_AL : cond_t'($urandom_range(15)),
					1'($urandom_range(1)), opcode_t'($urandom_range(15)),
					($urandom_range(3) != 0), 4'($urandom_range(15)),
					4'($urandom_range(15)), op2);
			end
			add_request(inst, pick_word(), pick_word());
		end
		total_requests = pending_requests.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// drain: every request accepted, every result back, then settle
		while (pending_requests.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Request driver: hold while stalled, otherwise offer the next request or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
				s_tvalid   <= 1'b1;
				s_tdata    <= pending_requests.pop_front();
				sent_count <= sent_count + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls plus one long hold-off in the no-idle phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && sent_count >= (total_requests * 2) / 3 + 40) begin
			m_tready  <= 1'b0;
			hold_left <= 120;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_idle_pct());
		end
	end

	// Monitor: predict on request accept, check on result accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_nzcv = 4'h0;
		end else begin
			if (s_tvalid && s_tready) begin
				want_res   = execute_dp(dp_request_t'(s_tdata), model_nzcv);
				model_nzcv = want_res.flags_out;
				expected_results.push_back(want_res);
			end
			if (m_tvalid && m_tready) begin
				got_res.executed     = m_tdata[0];
				got_res.write_enable = m_tdata[1];
				got_res.dest_index   = m_tdata[5:2];
				got_res.result_value = m_tdata[37:6];
				got_res.flags_out    = m_tdata[41:38];
				if (expected_results.size() == 0) begin
					$error("unexpected result: m_tdata %0h", m_tdata);
					fail_count++;
				end else begin
					want_res = expected_results.pop_front();
					compare_field("executed", 32'(want_res.executed),
						32'(got_res.executed));
					compare_field("write_enable", 32'(want_res.write_enable),
						32'(got_res.write_enable));
					compare_field("dest_index", 32'(want_res.dest_index),
						32'(got_res.dest_index));
					compare_field("result_value", want_res.result_value,
						got_res.result_value);
					compare_field("flags_out", 32'(want_res.flags_out),
						32'(got_res.flags_out));
				end
			end
		end
	end

endmodule
